// File: hw/rtl/doubly_linked_list_engine_assert.svh
// Assertion helpers used by the RTL top level.
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

// expr must hold on every clock outside reset
`define DLLE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("dlle: invariant violated");

// cons must hold in the cycle after ante
`define DLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dlle: sequence violated");

`endif

// File: hw/rtl/dlle_pkg.sv
`timescale 1ns / 1ps

package dlle_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int IDX_W        = 6;
	localparam logic [IDX_W-1:0] NULL_IDX = '1;
	localparam int CMP_W        = 7;
	localparam int MODE_W       = 3;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 6;
	localparam int ST_W         = 3;
	localparam int IN_TDATA_W   = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((ST_W + VAL_W + 7) / 8) * 8;

	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PREPEND = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

	typedef enum logic [ST_W-1:0] {
		ST_OK, ST_EMPTY, ST_FEW, ST_NOTFOUND, ST_FULL
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_APPEND, S_PREPEND, S_WALK, S_INS_B, S_SEARCH, S_READ, S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_START, OP_ADVANCE, OP_APPEND, OP_PREPEND, OP_INS_A, OP_INS_B,
		OP_UNLINK, OP_EMIT_ELEM, OP_EMIT_ST
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
		logic    ready;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              empty;
		logic              full;
		logic              pos_few;
		logic              walk_done;
		logic              match;
		logic              at_end;
		logic              out_free;
	} stat_t;

endpackage

// File: hw/rtl/dlle_ram.sv
`timescale 1ns / 1ps

module dlle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/dlle_ctrl.sv
`timescale 1ns / 1ps

module dlle_ctrl import dlle_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t  state_q, state_d;
	status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				st_d    = ST_OK;
				case (stat.mode)
					MODE_APPEND: begin
						if (stat.full) st_d = ST_FULL;
						else state_d = S_APPEND;
					end
					MODE_PREPEND: begin
						if (stat.empty) st_d = ST_EMPTY;
						else if (stat.full) st_d = ST_FULL;
						else state_d = S_PREPEND;
					end
					MODE_INSERT: begin
						// pool-full check comes after the position check
						if (stat.empty) st_d = ST_EMPTY;
						else if (stat.pos_few) st_d = ST_FEW;
						else if (stat.full) st_d = ST_FULL;
						else state_d = S_WALK;
					end
					MODE_DELETE: begin
						if (stat.empty) st_d = ST_EMPTY;
						else state_d = S_SEARCH;
					end
					MODE_READ: begin
						if (stat.empty) st_d = ST_EMPTY;
						else state_d = S_READ;
					end
					default: begin
						st_d = ST_OK;
					end
				endcase
			end
			S_APPEND, S_PREPEND, S_INS_B: begin
				state_d = S_EMIT;
				st_d    = ST_OK;
			end
			S_WALK: begin
				if (stat.walk_done) begin
					state_d = S_INS_B;
				end
			end
			S_SEARCH: begin
				if (stat.match) begin
					state_d = S_EMIT;
					st_d    = ST_OK;
				end else if (stat.at_end) begin
					state_d = S_EMIT;
					st_d    = ST_NOTFOUND;
				end
			end
			S_READ: begin
				if (stat.out_free && stat.at_end) begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.status = st_q;
		cmd.ready  = 1'b0;
		case (state_q)
			S_IDLE:    cmd.ready = 1'b1;
			S_DECODE:  cmd.op = OP_START;
			S_APPEND:  cmd.op = OP_APPEND;
			S_PREPEND: cmd.op = OP_PREPEND;
			S_WALK:    cmd.op = stat.walk_done ? OP_INS_A : OP_ADVANCE;
			S_INS_B:   cmd.op = OP_INS_B;
			S_SEARCH: begin
				if (stat.match) cmd.op = OP_UNLINK;
				else if (!stat.at_end) cmd.op = OP_ADVANCE;
			end
			S_READ: begin
				if (stat.out_free) cmd.op = OP_EMIT_ELEM;
			end
			S_EMIT: begin
				if (stat.out_free) cmd.op = OP_EMIT_ST;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: hw/rtl/dlle_dp.sv
`timescale 1ns / 1ps

module dlle_dp import dlle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmd_t                             cmd,
	input  logic                             s_tvalid,
	input  logic [IN_TDATA_W-1:0]            s_tdata,
	input  logic [MODE_W-1:0]                s_tuser,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [OUT_TDATA_W-1:0]           m_tdata,
	output logic                             m_tlast,
	output stat_t                            stat,
	output logic [CAPACITY-1:0]              free_map,
	output logic [$clog2(CAPACITY+1)-1:0]    cnt
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// item
	logic [MODE_W-1:0]       mode_q;
	logic signed [VAL_W-1:0] value_q;
	logic [POS_W-1:0]        pos_q;

	// list bookkeeping
	logic [IDX_W-1:0]    head_q, tail_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CAPACITY-1:0] free_q;

	// walk pointer and scratch
	logic [IDX_W-1:0] q_q, q_d, i_q, i_d, n_q, nq_q, alloc_idx;

	// output register
	logic                    m_valid_q;
	status_t                 m_status_q;
	logic signed [VAL_W-1:0] m_elem_q;
	logic                    m_last_q;

	logic [VAL_W-1:0] val_rd, val_wd;
	logic [IDX_W-1:0] nxt_rd, nxt_wd, prv_rd, prv_wd;
	logic [AW-1:0]    val_wa, nxt_wa, prv_wa;
	logic             val_we, nxt_we, prv_we;
	logic             accept, q_is_head, q_is_tail;

	assign accept    = s_tvalid && cmd.ready;
	assign q_is_head = (q_q == head_q);
	assign q_is_tail = (q_q == tail_q);

	// lowest free node
	always_comb begin
		alloc_idx = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (free_q[k]) alloc_idx = IDX_W'(k);
		end
	end

	assign stat.mode      = mode_q;
	assign stat.empty     = (cnt_q == '0);
	assign stat.full      = (cnt_q == CNT_W'(CAPACITY));
	assign stat.pos_few   = (CMP_W'(pos_q) > CMP_W'(cnt_q));
	assign stat.walk_done = ((CMP_W'(i_q) + CMP_W'(1)) >= CMP_W'(pos_q));
	assign stat.match     = (val_rd == value_q);
	assign stat.at_end    = ((CMP_W'(i_q) + CMP_W'(1)) == CMP_W'(cnt_q));
	assign stat.out_free  = !m_valid_q || m_tready;

	// the RAMs are read at q_d, so their outputs always show node q_q
	always_comb begin
		q_d = q_q;
		i_d = i_q;
		case (cmd.op)
			OP_START: begin
				q_d = head_q;
				i_d = '0;
			end
			OP_ADVANCE: begin
				q_d = nxt_rd;
				i_d = i_q + IDX_W'(1);
			end
			OP_EMIT_ELEM: begin
				if (!stat.at_end) begin
					q_d = nxt_rd;
					i_d = i_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		val_we = 1'b0;
		val_wa = n_q[AW-1:0];
		val_wd = value_q;
		nxt_we = 1'b0;
		nxt_wa = n_q[AW-1:0];
		nxt_wd = nxt_rd;
		prv_we = 1'b0;
		prv_wa = n_q[AW-1:0];
		prv_wd = q_q;
		case (cmd.op)
			OP_APPEND: begin
				val_we = 1'b1;
				nxt_we = !stat.empty;
				nxt_wa = tail_q[AW-1:0];
				nxt_wd = n_q;
				prv_we = 1'b1;
				prv_wd = tail_q;
			end
			OP_PREPEND: begin
				val_we = 1'b1;
				nxt_we = 1'b1;
				nxt_wd = head_q;
				prv_we = 1'b1;
				prv_wa = head_q[AW-1:0];
				prv_wd = n_q;
			end
			OP_INS_A: begin
				val_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			OP_INS_B: begin
				nxt_we = 1'b1;
				nxt_wa = q_q[AW-1:0];
				nxt_wd = n_q;
				prv_we = !q_is_tail;
				prv_wa = nq_q[AW-1:0];
				prv_wd = n_q;
			end
			OP_UNLINK: begin
				nxt_we = !q_is_head;
				nxt_wa = prv_rd[AW-1:0];
				nxt_wd = nxt_rd;
				prv_we = !q_is_tail;
				prv_wa = nxt_rd[AW-1:0];
				prv_wd = prv_rd;
			end
			default: ;
		endcase
	end

	dlle_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_wa),
		.wdata (val_wd),
		.raddr (q_d[AW-1:0]),
		.rdata (val_rd)
	);

	dlle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_wa),
		.wdata (nxt_wd),
		.raddr (q_d[AW-1:0]),
		.rdata (nxt_rd)
	);

	dlle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_wa),
		.wdata (prv_wd),
		.raddr (q_d[AW-1:0]),
		.rdata (prv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= NULL_IDX;
			tail_q    <= NULL_IDX;
			cnt_q     <= '0;
			free_q    <= '1;
			m_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_APPEND: begin
					tail_q <= n_q;
					if (stat.empty) head_q <= n_q;
					cnt_q                <= cnt_q + CNT_W'(1);
					free_q[n_q[AW-1:0]] <= 1'b0;
				end
				OP_PREPEND: begin
					head_q               <= n_q;
					cnt_q                <= cnt_q + CNT_W'(1);
					free_q[n_q[AW-1:0]] <= 1'b0;
				end
				OP_INS_B: begin
					if (q_is_tail) tail_q <= n_q;
					cnt_q                <= cnt_q + CNT_W'(1);
					free_q[n_q[AW-1:0]] <= 1'b0;
				end
				OP_UNLINK: begin
					cnt_q                <= cnt_q - CNT_W'(1);
					free_q[q_q[AW-1:0]] <= 1'b1;
					// removing the only element empties the list
					if (cnt_q == CNT_W'(1)) begin
						head_q <= NULL_IDX;
						tail_q <= NULL_IDX;
					end else begin
						if (q_is_head) head_q <= nxt_rd;
						if (q_is_tail) tail_q <= prv_rd;
					end
				end
				default: ;
			endcase
			if (cmd.op == OP_EMIT_ELEM || cmd.op == OP_EMIT_ST) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= s_tuser;
			value_q <= s_tdata[VAL_W-1:0];
			pos_q   <= s_tdata[VAL_W+POS_W-1:VAL_W];
		end
		q_q <= q_d;
		i_q <= i_d;
		if (cmd.op == OP_START) n_q <= alloc_idx;
		if (cmd.op == OP_INS_A) nq_q <= nxt_rd;
		if (cmd.op == OP_EMIT_ELEM) begin
			m_status_q <= ST_OK;
			m_elem_q   <= val_rd;
			m_last_q   <= stat.at_end;
		end else if (cmd.op == OP_EMIT_ST) begin
			m_status_q <= cmd.status;
			m_elem_q   <= '0;
			m_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - ST_W - VAL_W)'(0), m_elem_q, m_status_q};
	assign m_tlast  = m_last_q;
	assign free_map = free_q;
	assign cnt      = cnt_q;

endmodule

// File: hw/rtl/doubly_linked_list_engine.sv
// Sequence: each item is decoded, then append and prepend link the new node, insert walks to
// its position and links the node in two steps, delete searches until a match or the tail, and
// read out emits one element per node; an item rejected at decode goes straight to its status.
// Throughput: one item at a time; walks, searches and read outs visit one node per cycle
// through the registered link memories, and a read out waits while the result output stalls.
// Reset (arst_n low, asynchronous) empties the list and frees every node; memories kept.
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_assert.svh"

module doubly_linked_list_engine import dlle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value[31:0], position[37:32], zero pad
	input  logic [MODE_W-1:0]      s_tuser,  // mode[2:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // status[2:0], element[34:3], zero pad
	output logic                   m_tlast
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	cmd_t                cmd;
	stat_t               stat;
	logic [CAPACITY-1:0] free_map;
	logic [CNT_W-1:0]    cnt;

	assign s_tready = cmd.ready;

	dlle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	dlle_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.stat     (stat),
		.free_map (free_map),
		.cnt      (cnt)
	);

	`DLLE_ASSERT_ALWAYS(a_count_cap, clk, arst_n, int'(cnt) <= CAPACITY)
	`DLLE_ASSERT_ALWAYS(a_pool_balance, clk, arst_n, $countones(free_map) + int'(cnt) == CAPACITY)
	`DLLE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

// File: tb/sv/tb_doubly_linked_list_engine.sv
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine import dlle_pkg::*; ();

	localparam logic [MODE_W-1:0] MODE_RSVD_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_HI  = 3'd7;
	localparam int DIRECTED_ITEMS = 24;
	localparam int RANDOM_ITEMS   = 146;
	localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
	localparam int QUIET_TAIL     = 30;
	localparam int HOLD_AT        = DIRECTED_ITEMS + 80;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  pos;
	} list_cmd_t;

	// Tracks the list contents and the results each accepted command must produce.
	class list_scoreboard;
		typedef struct {
			status_t          st;
			logic [VAL_W-1:0] elem;
			logic             last;
		} list_result_t;

		logic [VAL_W-1:0] node_val[64];
		logic [IDX_W-1:0] fwd[64];
		logic [IDX_W-1:0] back[64];
		logic [IDX_W-1:0] head;
		logic [IDX_W-1:0] tail;
		logic [63:0]      free_nodes;
		int unsigned      len;
		list_result_t     expected[$];
		int               errors;

		function new();
			head       = NULL_IDX;
			tail       = NULL_IDX;
			free_nodes = {{(64 - CAPACITY_DEF){1'b0}}, {CAPACITY_DEF{1'b1}}};
			len        = 0;
			errors     = 0;
		endfunction

		function void push(status_t st, logic [VAL_W-1:0] elem, logic last);
			list_result_t r;
			r.st   = st;
			r.elem = elem;
			r.last = last;
			expected.push_back(r);
		endfunction

		// lowest free node, -1 when the pool is exhausted
		function int grab_node(logic [VAL_W-1:0] v);
			for (int i = 0; i < CAPACITY_DEF; i++) begin
				if (free_nodes[i]) begin
					free_nodes[i] = 1'b0;
					node_val[i]   = v;
					fwd[i]        = NULL_IDX;
					back[i]       = NULL_IDX;
					return i;
				end
			end
			return -1;
		endfunction

		function void note_item(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value,
				logic [POS_W-1:0] pos);
			int n;
			int unsigned walk_len;
			logic [IDX_W-1:0] q;
			logic [IDX_W-1:0] nx;
			logic [IDX_W-1:0] pv;
			bit hit;
			case (mode)
				MODE_APPEND: begin
					n = grab_node(value);
					if (n < 0) begin
						push(ST_FULL, '0, 1'b1);
					end else begin
						if (len == 0) begin
							head = IDX_W'(n);
						end else begin
							fwd[tail] = IDX_W'(n);
							back[n]   = tail;
						end
						tail = IDX_W'(n);
						len++;
						push(ST_OK, '0, 1'b1);
					end
				end
				MODE_PREPEND: begin
					if (len == 0) begin
						push(ST_EMPTY, '0, 1'b1);
					end else begin
						n = grab_node(value);
						if (n < 0) begin
							push(ST_FULL, '0, 1'b1);
						end else begin
							fwd[n]     = head;
							back[head] = IDX_W'(n);
							head       = IDX_W'(n);
							len++;
							push(ST_OK, '0, 1'b1);
						end
					end
				end
				MODE_INSERT: begin
					if (len == 0) begin
						push(ST_EMPTY, '0, 1'b1);
					end else if (pos > len) begin
						push(ST_FEW, '0, 1'b1);
					end else begin
						q = head;
						for (int i = 1; i < pos; i++)
							q = fwd[q];
						// pool check comes after the position check
						n = grab_node(value);
						if (n < 0) begin
							push(ST_FULL, '0, 1'b1);
						end else begin
							back[n] = q;
							if (q == tail) begin
								tail = IDX_W'(n);
							end else begin
								fwd[n]      = fwd[q];
								back[fwd[q]] = IDX_W'(n);
							end
							fwd[q] = IDX_W'(n);
							len++;
							push(ST_OK, '0, 1'b1);
						end
					end
				end
				MODE_DELETE: begin
					if (len == 0) begin
						push(ST_EMPTY, '0, 1'b1);
					end else begin
						hit      = 1'b0;
						walk_len = len;
						q        = head;
						for (int i = 0; i < walk_len && !hit; i++) begin
							if (node_val[q] == value) begin
								hit = 1'b1;
								nx  = fwd[q];
								pv  = back[q];
								if (q == head)
									head = nx;
								else
									fwd[pv] = nx;
								if (q == tail)
									tail = pv;
								else
									back[nx] = pv;
								free_nodes[q] = 1'b1;
								len--;
								if (len == 0) begin
									head = NULL_IDX;
									tail = NULL_IDX;
								end
							end else begin
								q = fwd[q];
							end
						end
						push(hit ? ST_OK : ST_NOTFOUND, '0, 1'b1);
					end
				end
				MODE_READ: begin
					if (len == 0) begin
						push(ST_EMPTY, '0, 1'b1);
					end else begin
						q = head;
						for (int i = 0; i < len; i++) begin
							push(ST_OK, node_val[q], (i + 1 == len));
							q = fwd[q];
						end
					end
				end
				default: push(ST_OK, '0, 1'b1);
			endcase
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] elem, logic last);
			list_result_t e;
			if (expected.size() == 0) begin
				$error("unexpected result transfer: status %0d element %0d last %0b",
					st, $signed(elem), last);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				errors++;
			end
			if (elem !== e.elem) begin
				$error("element: expected %0d, got %0d", $signed(e.elem), $signed(elem));
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, last);
				errors++;
			end
		endfunction

		// value of a random stored element, so deletes mostly hit
		function logic [VAL_W-1:0] pick_stored();
			logic [IDX_W-1:0] q;
			int unsigned steps;
			if (len == 0)
				return $urandom;
			steps = $urandom_range(0, len - 1);
			q     = head;
			for (int i = 0; i < steps; i++)
				q = fwd[q];
			return node_val[q];
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // value[31:0], position[37:32], zero pad
	logic [MODE_W-1:0]      s_tuser;   // mode[2:0]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // status[2:0], element[34:3], zero pad
	logic                   m_tlast;

	list_scoreboard sb = new();
	int items_in   = 0;
	int stall_run  = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	bit send_quiet = 1'b0;

	list_cmd_t directed_plan[DIRECTED_ITEMS] = '{
		'{MODE_READ,     32'h0000_0000, 6'd0},
		'{MODE_PREPEND,  32'h0000_0011, 6'd0},
		'{MODE_INSERT,   32'h0000_0022, 6'd1},
		'{MODE_DELETE,   32'h0000_0033, 6'd0},
		'{MODE_APPEND,   32'h0000_0005, 6'd0},
		'{MODE_DELETE,   32'h0000_0005, 6'd0},   // only element: list empties
		'{MODE_READ,     32'h0000_0000, 6'd0},
		'{MODE_APPEND,   32'h8000_0000, 6'd0},
		'{MODE_APPEND,   32'h7FFF_FFFF, 6'd0},
		'{MODE_PREPEND,  32'hFFFF_FFFF, 6'd0},
		'{MODE_INSERT,   32'h0000_0000, 6'd0},
		'{MODE_INSERT,   32'h0000_0001, 6'd1},
		'{MODE_INSERT,   32'hAAAA_AAAA, 6'd5},   // after the tail
		'{MODE_INSERT,   32'h5555_5555, 6'd7},
		'{MODE_INSERT,   32'h5555_5555, 6'd63},
		'{MODE_READ,     32'h0000_0000, 6'd0},
		'{MODE_DELETE,   32'h0000_3039, 6'd0},
		'{MODE_DELETE,   32'hFFFF_FFFF, 6'd0},
		'{MODE_DELETE,   32'hAAAA_AAAA, 6'd0},
		'{MODE_DELETE,   32'h0000_0000, 6'd0},
		'{MODE_RSVD_LO,  32'h5555_5555, 6'd63},
		'{MODE_RSVD_MID, 32'hFFFF_FFFF, 6'd42},
		'{MODE_RSVD_HI,  32'h0000_0000, 6'd21},
		'{MODE_READ,     32'h0000_0000, 6'd0}
	};

	doubly_linked_list_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// transfer checks and the watchdog
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata[ST_W-1:0], m_tdata[ST_W +: VAL_W], m_tlast);
		if (s_tvalid && s_tready) begin
			sb.note_item(s_tuser, s_tdata[VAL_W-1:0], s_tdata[VAL_W +: POS_W]);
			items_in++;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_run = 0;
		else
			stall_run++;
		if (stall_run >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: short random stalls, one long hold-off, none near the end
	always @(negedge clk) begin
		if (items_in >= HOLD_AT && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (items_in < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0, 1: return VAL_W'($urandom_range(0, 7)) - VAL_W'(4);
			2: return $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(list_cmd_t c);
		if (!send_quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.mode;
		s_tdata  <= IN_TDATA_W'({c.pos, c.value});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		list_cmd_t c;
		int r;
		int t_app;
		int t_pre;
		int t_ins;
		int t_del;
		int t_rd;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i])
			send_item(directed_plan[i]);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// growth, mixed, shrink, mixed
			if (k < 60) begin
				t_app = 40; t_pre = 55; t_ins = 80; t_del = 88; t_rd = 96;
			end else if (k < 95 || k >= 130) begin
				t_app = 20; t_pre = 30; t_ins = 50; t_del = 75; t_rd = 92;
			end else begin
				t_app = 8; t_pre = 12; t_ins = 20; t_del = 85; t_rd = 95;
			end
			send_quiet = (k >= RANDOM_ITEMS - QUIET_TAIL);
			r = $urandom_range(0, 99);
			if (r < t_app)
				c.mode = MODE_APPEND;
			else if (r < t_pre)
				c.mode = MODE_PREPEND;
			else if (r < t_ins)
				c.mode = MODE_INSERT;
			else if (r < t_del)
				c.mode = MODE_DELETE;
			else if (r < t_rd)
				c.mode = MODE_READ;
			else
				c.mode = MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
			if (c.mode == MODE_DELETE && $urandom_range(0, 9) < 7)
				c.value = sb.pick_stored();
			else
				c.value = pick_value();
			case ($urandom_range(0, 7))
				0: c.pos = POS_W'($urandom_range(0, 63));
				1: c.pos = POS_W'(sb.len + 1);
				default: c.pos = POS_W'($urandom_range(0, sb.len));
			endcase
			send_item(c);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (CAPACITY_DEF + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dlle_pkg.sv
hw/rtl/dlle_ram.sv
hw/rtl/dlle_ctrl.sv
hw/rtl/dlle_dp.sv
hw/rtl/doubly_linked_list_engine.sv
tb/sv/tb_doubly_linked_list_engine.sv
